[rtl/core/ahfr_pkg.sv]
`default_nettype none

package ahfr_pkg;

   localparam int DEFAULT_MAX_FRAME_BYTES = 64;

   localparam logic [7:0] CRC_POLY = 8'h31;
   localparam logic [7:0] CRC_INIT = 8'hFF;
   localparam logic [7:0] CRC_MSB  = 8'h80;

   localparam logic [7:0] CHAR_COLON = 8'h3A;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_EMPTY    = 3'd1;
   localparam logic [2:0] ST_BAD_LEN  = 3'd2;
   localparam logic [2:0] ST_BAD_CRC  = 3'd3;
   localparam logic [2:0] ST_BAD_ADDR = 3'd4;
   localparam logic [2:0] ST_BAD_CMD  = 3'd5;

   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXPECTED_LENGTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OWN_ADDRESS      = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_EXPECTED_COMMAND = 2'd2;

   localparam logic [6:0] EXPECTED_LENGTH_RESET  = 7'd4;
   localparam logic [7:0] OWN_ADDRESS_RESET      = 8'd0;
   localparam logic [7:0] EXPECTED_COMMAND_RESET = 8'd0;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } hex_digit_type;

   function automatic hex_digit_type hex_decode(input logic [7:0] c);
      hex_digit_type d;
      d.valid = 1'b1;
      d.value = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         d.value = 4'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         d.value = 4'(c - 8'h57);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         d.value = 4'(c - 8'h37);
      end else begin
         d.valid = 1'b0;
      end
      return d;
   endfunction

   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] r;
      r = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         if ((r & CRC_MSB) != 8'd0) begin
            r = {r[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            r = {r[6:0], 1'b0};
         end
      end
      return r;
   endfunction

endpackage

`default_nettype wire

[rtl/core/ahfr_rsp_buf.sv]
`default_nettype none

module ahfr_rsp_buf #(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   input  wire logic [WIDTH-1:0] in_data,
   output logic                  in_full,
   output logic                  out_valid,
   output logic [WIDTH-1:0]      out_data,
   input  wire logic             out_stall
);

   logic             out_valid_ff, out_valid_in;
   logic [WIDTH-1:0] out_data_ff, out_data_in;
   logic             skid_valid_ff, skid_valid_in;
   logic [WIDTH-1:0] skid_data_ff, skid_data_in;
   logic             out_take;

   assign out_take = out_valid_ff & ~out_stall;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (out_take) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (in_valid) begin
         if (!out_valid_ff || out_take) begin
            out_data_in  = in_data;
            out_valid_in = 1'b1;
         end else begin
            skid_data_in  = in_data;
            skid_valid_in = 1'b1;
         end
      end else if (out_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign in_full   = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule

`default_nettype wire

[rtl/core/ascii_hex_frame_receiver_crc8_core.sv]
// ASCII hex frame receiver with CRC-8 check.
// req_ channel: one received character per word (req_rx_char), taken when
// req_valid is high and req_stall is low. ':' starts a frame, hex digit pairs
// become bytes, CR or LF closes the frame with a status report.
// rsp_ channel: a data word (item_kind 0, byte value and index) for every
// decoded byte up to MAX_FRAME_BYTES, a report word (item_kind 1, status,
// length, computed crc) for every terminator; other characters give no word.
// csr_ port: index 0 expected length, 1 own address, 2 expected command;
// csr_ready is always high; the user must write only while idle (unchecked).
// A result word is registered in the result buffer before it shows on rsp_.
// Throughput: one character per cycle while req_stall is low; the
// next-state and crc logic is a single registered pass from the accepted
// character to the frame state and result register.
// Stall: while rsp_stall holds, one further result is kept in a skid slot;
// req_stall then rises until the held result moves out.
// Reset: synchronous; clears the frame state, loads register defaults
// (length 4, address 0, command 0) and empties the result buffer.
`default_nettype none

module ascii_hex_frame_receiver_crc8_core #(
   parameter int MAX_FRAME_BYTES = ahfr_pkg::DEFAULT_MAX_FRAME_BYTES,
   localparam int LEN_W = $clog2(MAX_FRAME_BYTES + 1)
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [7:0]                       req_rx_char,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic                                  rsp_item_kind,
   output logic [7:0]                            rsp_byte_value,
   output logic [5:0]                            rsp_byte_index,
   output logic [2:0]                            rsp_frame_status,
   output logic [LEN_W-1:0]                      rsp_frame_length,
   output logic [7:0]                            rsp_computed_crc,
   input  wire logic                             csr_valid,
   output logic                                  csr_ready,
   input  wire logic [ahfr_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [7:0]                       csr_data
);

   import ahfr_pkg::*;

   localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 2);
   localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;
   localparam int RSP_W = 1 + 8 + 6 + 3 + LEN_W + 8;
   localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_FRAME_BYTES);
   localparam logic [CNT_W-1:0] CNT_OVER = CNT_W'(MAX_FRAME_BYTES + 1);

   logic [6:0]       expected_length_ff;
   logic [7:0]       own_address_ff;
   logic [7:0]       expected_command_ff;

   logic [3:0]       pending_nibble_ff, pending_nibble_in;
   logic             nibble_waiting_ff, nibble_waiting_in;
   logic [CNT_W-1:0] byte_count_ff, byte_count_in;
   logic [7:0]       crc_running_ff, crc_running_in;
   logic [7:0]       crc_before_last_ff, crc_before_last_in;
   logic [7:0]       last_byte_ff, last_byte_in;
   logic [7:0]       address_byte_ff, address_byte_in;
   logic [7:0]       command_byte_ff, command_byte_in;

   logic             accept;
   hex_digit_type    digit;
   logic [7:0]       new_byte;
   logic [CMP_W-1:0] count_wide;
   logic             res_valid;
   logic             res_kind;
   logic [7:0]       res_value;
   logic [5:0]       res_index;
   logic [2:0]       res_status;
   logic [LEN_W-1:0] res_length;
   logic [7:0]       res_crc;
   logic [RSP_W-1:0] res_word;
   logic [RSP_W-1:0] rsp_word;
   logic             buf_full;

   assign accept     = req_valid & ~req_stall;
   assign digit      = hex_decode(req_rx_char);
   assign new_byte   = {pending_nibble_ff, digit.value};
   assign count_wide = CMP_W'(byte_count_ff);

   always_comb begin
      pending_nibble_in  = pending_nibble_ff;
      nibble_waiting_in  = nibble_waiting_ff;
      byte_count_in      = byte_count_ff;
      crc_running_in     = crc_running_ff;
      crc_before_last_in = crc_before_last_ff;
      last_byte_in       = last_byte_ff;
      address_byte_in    = address_byte_ff;
      command_byte_in    = command_byte_ff;
      res_valid  = 1'b0;
      res_kind   = KIND_DATA;
      res_value  = 8'd0;
      res_index  = 6'd0;
      res_status = ST_OK;
      res_length = '0;
      res_crc    = 8'd0;
      if (accept) begin
         if (req_rx_char == CHAR_COLON) begin
            pending_nibble_in  = 4'd0;
            nibble_waiting_in  = 1'b0;
            byte_count_in      = '0;
            crc_running_in     = CRC_INIT;
            crc_before_last_in = CRC_INIT;
            last_byte_in       = 8'd0;
            address_byte_in    = 8'd0;
            command_byte_in    = 8'd0;
         end else if (req_rx_char == CHAR_LF || req_rx_char == CHAR_CR) begin
            res_valid = 1'b1;
            res_kind  = KIND_REPORT;
            res_crc   = crc_before_last_ff;
            res_length = (byte_count_ff > CNT_MAX) ? LEN_W'(MAX_FRAME_BYTES)
                                                   : LEN_W'(byte_count_ff);
            priority if (byte_count_ff == '0 && !nibble_waiting_ff) begin
               res_status = ST_EMPTY;
            end else if (nibble_waiting_ff || byte_count_ff > CNT_MAX ||
                         count_wide != CMP_W'(expected_length_ff)) begin
               res_status = ST_BAD_LEN;
            end else if (last_byte_ff != crc_before_last_ff) begin
               res_status = ST_BAD_CRC;
            end else if (address_byte_ff != own_address_ff) begin
               res_status = ST_BAD_ADDR;
            end else if (command_byte_ff != expected_command_ff) begin
               res_status = ST_BAD_CMD;
            end else begin
               res_status = ST_OK;
            end
         end else if (digit.valid) begin
            if (!nibble_waiting_ff) begin
               pending_nibble_in = digit.value;
               nibble_waiting_in = 1'b1;
            end else begin
               pending_nibble_in = 4'd0;
               nibble_waiting_in = 1'b0;
               if (byte_count_ff >= CNT_MAX) begin
                  byte_count_in = CNT_OVER;
               end else begin
                  if (byte_count_ff == CNT_W'(0)) begin
                     address_byte_in = new_byte;
                  end
                  if (byte_count_ff == CNT_W'(1)) begin
                     command_byte_in = new_byte;
                  end
                  crc_before_last_in = crc_running_ff;
                  crc_running_in     = crc8_update(crc_running_ff, new_byte);
                  last_byte_in       = new_byte;
                  byte_count_in      = byte_count_ff + CNT_W'(1);
                  res_valid = 1'b1;
                  res_kind  = KIND_DATA;
                  res_value = new_byte;
                  res_index = count_wide[5:0];
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_nibble_ff  <= 4'd0;
         nibble_waiting_ff  <= 1'b0;
         byte_count_ff      <= '0;
         crc_running_ff     <= CRC_INIT;
         crc_before_last_ff <= CRC_INIT;
         last_byte_ff       <= 8'd0;
         address_byte_ff    <= 8'd0;
         command_byte_ff    <= 8'd0;
      end else begin
         pending_nibble_ff  <= pending_nibble_in;
         nibble_waiting_ff  <= nibble_waiting_in;
         byte_count_ff      <= byte_count_in;
         crc_running_ff     <= crc_running_in;
         crc_before_last_ff <= crc_before_last_in;
         last_byte_ff       <= last_byte_in;
         address_byte_ff    <= address_byte_in;
         command_byte_ff    <= command_byte_in;
      end
   end

   // register writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_length_ff  <= EXPECTED_LENGTH_RESET;
         own_address_ff      <= OWN_ADDRESS_RESET;
         expected_command_ff <= EXPECTED_COMMAND_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_EXPECTED_LENGTH:  expected_length_ff  <= csr_data[6:0];
            CSR_OWN_ADDRESS:      own_address_ff      <= csr_data;
            CSR_EXPECTED_COMMAND: expected_command_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   assign res_word = {res_kind, res_value, res_index, res_status, res_length, res_crc};

   ahfr_rsp_buf #(
      .WIDTH(RSP_W)
   ) u_rsp_buf (
      .clock    (clock),
      .reset    (reset),
      .in_valid (res_valid),
      .in_data  (res_word),
      .in_full  (buf_full),
      .out_valid(rsp_valid),
      .out_data (rsp_word),
      .out_stall(rsp_stall)
   );

   assign req_stall = buf_full;
   assign {rsp_item_kind, rsp_byte_value, rsp_byte_index, rsp_frame_status,
           rsp_frame_length, rsp_computed_crc} = rsp_word;

   a_count_bounded : assert property (@(posedge clock) disable iff (reset)
      byte_count_ff <= CNT_OVER)
      else $error("byte count past overflow mark");

   a_colon_clears : assert property (@(posedge clock) disable iff (reset)
      accept && req_rx_char == CHAR_COLON |=> byte_count_ff == '0 && !nibble_waiting_ff)
      else $error("frame start did not clear accumulation");

   a_full_means_held : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no result on output");

   a_report_length : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item_kind == KIND_REPORT |->
         rsp_frame_length <= LEN_W'(MAX_FRAME_BYTES))
      else $error("reported length above frame limit");

endmodule

`default_nettype wire

[bench/ahfr_checker.sv]
module ahfr_checker
   import ahfr_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic                   req_stall,
   input  wire logic [7:0]             req_rx_char,
   input  wire logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   input  wire logic                   rsp_item_kind,
   input  wire logic [7:0]             rsp_byte_value,
   input  wire logic [5:0]             rsp_byte_index,
   input  wire logic [2:0]             rsp_frame_status,
   input  wire logic [6:0]             rsp_frame_length,
   input  wire logic [7:0]             rsp_computed_crc,
   input  wire logic                   csr_valid,
   input  wire logic                   csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [7:0]             csr_data,
   output int                          fail_count,
   output int                          outstanding
);

   localparam int MAX_BYTES = DEFAULT_MAX_FRAME_BYTES;

   typedef struct packed {
      logic       kind;
      logic [7:0] value;
      logic [5:0] index;
      logic [2:0] status;
      logic [6:0] length;
      logic [7:0] crc;
   } rx_word_type;

   rx_word_type rx_word_q[$];

   logic [6:0] exp_len;
   logic [7:0] own_addr;
   logic [7:0] exp_cmd;

   logic [3:0] high_nib;
   logic       nib_held;
   logic [6:0] byte_cnt;
   logic [7:0] crc_run;
   logic [7:0] crc_prev;
   logic [7:0] last_b;
   logic [7:0] addr_b;
   logic [7:0] cmd_b;

   // bitwise msb-first crc-8, feedback taken per data bit
   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
         fb  = crc[7] ^ b[i];
         crc = {crc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
      end
      return crc;
   endfunction

   // {is digit, value}
   function automatic logic [4:0] nibble_of(input logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return {1'b1, c[3:0]};
      if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) return {1'b1, c[3:0] + 4'd9};
      return 5'd0;
   endfunction

   function automatic void clear_frame();
      high_nib = 4'd0;
      nib_held = 1'b0;
      byte_cnt = 7'd0;
      crc_run  = CRC_INIT;
      crc_prev = CRC_INIT;
      last_b   = 8'd0;
      addr_b   = 8'd0;
      cmd_b    = 8'd0;
   endfunction

   task automatic track_char(input logic [7:0] c);
      logic [4:0]  nib;
      logic [7:0]  b;
      logic [2:0]  st;
      rx_word_type w;
      w   = '0;
      nib = nibble_of(c);
      if (c == CHAR_COLON) begin
         clear_frame();
      end else if (c == CHAR_LF || c == CHAR_CR) begin
         if (byte_cnt == 0 && !nib_held) begin
            st = ST_EMPTY;
         end else if (nib_held || byte_cnt > MAX_BYTES || byte_cnt != exp_len) begin
            st = ST_BAD_LEN;
         end else if (last_b != crc_prev) begin
            st = ST_BAD_CRC;
         end else if (addr_b != own_addr) begin
            st = ST_BAD_ADDR;
         end else if (cmd_b != exp_cmd) begin
            st = ST_BAD_CMD;
         end else begin
            st = ST_OK;
         end
         w.kind   = KIND_REPORT;
         w.status = st;
         w.length = (byte_cnt > MAX_BYTES) ? 7'(MAX_BYTES) : byte_cnt;
         w.crc    = crc_prev;
         rx_word_q.push_back(w);
      end else if (nib[4]) begin
         if (!nib_held) begin
            high_nib = nib[3:0];
            nib_held = 1'b1;
         end else begin
            b        = {high_nib, nib[3:0]};
            nib_held = 1'b0;
            high_nib = 4'd0;
            if (byte_cnt >= MAX_BYTES) begin
               // overflow mark, byte dropped
               byte_cnt = 7'(MAX_BYTES + 1);
            end else begin
               if (byte_cnt == 0) addr_b = b;
               if (byte_cnt == 1) cmd_b = b;
               crc_prev = crc_run;
               crc_run  = crc8_step(crc_run, b);
               last_b   = b;
               w.kind   = KIND_DATA;
               w.value  = b;
               w.index  = byte_cnt[5:0];
               rx_word_q.push_back(w);
               byte_cnt = byte_cnt + 7'd1;
            end
         end
      end
   endtask

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rx_word_type want;
      if (reset) begin
         clear_frame();
         exp_len  = EXPECTED_LENGTH_RESET;
         own_addr = OWN_ADDRESS_RESET;
         exp_cmd  = EXPECTED_COMMAND_RESET;
         rx_word_q.delete();
      end else begin
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            if (rx_word_q.size() == 0) begin
               $error("rsp word with nothing expected: kind %0h", rsp_item_kind);
               fail_count++;
            end else begin
               want = rx_word_q.pop_front();
               check_field("item_kind", 8'(want.kind), 8'(rsp_item_kind));
               check_field("byte_value", want.value, rsp_byte_value);
               check_field("byte_index", 8'(want.index), 8'(rsp_byte_index));
               check_field("frame_status", 8'(want.status), 8'(rsp_frame_status));
               check_field("frame_length", 8'(want.length), 8'(rsp_frame_length));
               check_field("computed_crc", want.crc, rsp_computed_crc);
            end
         end
         if (csr_valid === 1'b1 && csr_ready === 1'b1) begin
            case (csr_index)
               CSR_EXPECTED_LENGTH:  exp_len  = csr_data[6:0];
               CSR_OWN_ADDRESS:      own_addr = csr_data;
               CSR_EXPECTED_COMMAND: exp_cmd  = csr_data;
               default: ;
            endcase
         end
         if (req_valid === 1'b1 && req_stall === 1'b0) track_char(req_rx_char);
      end
      outstanding = rx_word_q.size();
   end

endmodule

[bench/tb_ascii_hex_frame_receiver_crc8_core.sv]
module tb_ascii_hex_frame_receiver_crc8_core;
   import ahfr_pkg::*;

   localparam int LEN_W = $clog2(DEFAULT_MAX_FRAME_BYTES + 1);
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_valid   = 1'b0;
   logic                   req_stall;
   logic [7:0]             req_rx_char = 8'd0;
   logic                   rsp_valid;
   logic                   rsp_stall   = 1'b0;
   logic                   rsp_item_kind;
   logic [7:0]             rsp_byte_value;
   logic [5:0]             rsp_byte_index;
   logic [2:0]             rsp_frame_status;
   logic [LEN_W-1:0]       rsp_frame_length;
   logic [7:0]             rsp_computed_crc;
   logic                   csr_valid   = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index   = '0;
   logic [7:0]             csr_data    = 8'd0;

   int fail_count;
   int outstanding;
   int idle_pct   = 0;
   int stall_pct  = 0;
   int word_count = 0;

   logic [6:0] cfg_len  = EXPECTED_LENGTH_RESET;
   logic [7:0] cfg_addr = OWN_ADDRESS_RESET;
   logic [7:0] cfg_cmd  = EXPECTED_COMMAND_RESET;
   logic [7:0] frame_q[$];
   logic [7:0] odd_chars[7] = '{8'h00, 8'hFF, 8'h2F, 8'h40, 8'h47, 8'h60, 8'h67};

   ascii_hex_frame_receiver_crc8_core i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_char      (req_rx_char),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_item_kind    (rsp_item_kind),
      .rsp_byte_value   (rsp_byte_value),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_frame_status (rsp_frame_status),
      .rsp_frame_length (rsp_frame_length),
      .rsp_computed_crc (rsp_computed_crc),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   ahfr_checker i_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rx_char      (req_rx_char),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_item_kind    (rsp_item_kind),
      .rsp_byte_value   (rsp_byte_value),
      .rsp_byte_index   (rsp_byte_index),
      .rsp_frame_status (rsp_frame_status),
      .rsp_frame_length (rsp_frame_length),
      .rsp_computed_crc (rsp_computed_crc),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .fail_count       (fail_count),
      .outstanding      (outstanding)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   initial begin
      #2000000;
      $display("[ascii_hex_frame_receiver_crc8_core] ERROR");
      $finish;
   end

   function automatic bit is_hex(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
             (c >= 8'h41 && c <= 8'h46);
   endfunction

   // digit in random case
   function automatic logic [7:0] hex_char(input logic [3:0] n);
      if (n < 10) return 8'h30 + 8'(n);
      return ($urandom_range(0, 1) ? 8'h37 : 8'h57) + 8'(n);
   endfunction

   function automatic logic [7:0] noise_char();
      logic [7:0] c;
      do begin
         c = 8'($urandom_range(0, 255));
      end while (is_hex(c) || c == CHAR_COLON || c == CHAR_LF || c == CHAR_CR);
      return c;
   endfunction

   function automatic logic [7:0] frame_crc(input int n);
      logic [7:0] crc;
      crc = CRC_INIT;
      for (int i = 0; i < n; i++) begin
         crc = crc ^ frame_q[i];
         repeat (8) crc = crc[7] ? ({crc[6:0], 1'b0} ^ CRC_POLY) : {crc[6:0], 1'b0};
      end
      return crc;
   endfunction

   task automatic send_char(input logic [7:0] c);
      req_rx_char <= c;
      req_valid   <= 1'b1;
      do @(posedge clock); while (req_stall !== 1'b0);
      if (is_hex(c) || c == CHAR_COLON || c == CHAR_LF || c == CHAR_CR) word_count++;
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic send_byte(input logic [7:0] b);
      if ($urandom_range(0, 15) == 0) send_char(noise_char());
      send_char(hex_char(b[7:4]));
      send_char(hex_char(b[3:0]));
   endtask

   task automatic send_frame(input bit colon, input bit odd, input int term);
      if (colon) send_char(CHAR_COLON);
      foreach (frame_q[i]) send_byte(frame_q[i]);
      if (odd) send_char(hex_char(4'($urandom_range(0, 15))));
      case (term)
         0: send_char(CHAR_CR);
         1: send_char(CHAR_LF);
         2: begin
            send_char(CHAR_CR);
            send_char(CHAR_LF);
         end
         default: begin
            send_char(CHAR_LF);
            send_char(CHAR_LF);
         end
      endcase
   endtask

   task automatic random_frame();
      int pick;
      int n;
      int r;
      pick = $urandom_range(0, 99);
      if (pick >= 95) begin
         // loose stream of digits, colons, terminators and junk
         repeat ($urandom_range(1, 12)) begin
            r = $urandom_range(0, 9);
            if (r < 5) send_char(hex_char(4'($urandom_range(0, 15))));
            else if (r == 5) send_char(CHAR_COLON);
            else if (r == 6) send_char(CHAR_CR);
            else if (r == 7) send_char(CHAR_LF);
            else send_char(noise_char());
         end
         return;
      end
      if (pick >= 77 && pick < 87) n = $urandom_range(0, 8);
      else if (pick >= 87 && pick < 90) n = $urandom_range(60, 70);
      else if (cfg_len >= 2 && cfg_len <= 64) n = cfg_len;
      else n = $urandom_range(2, 8);
      frame_q.delete();
      repeat (n) frame_q.push_back(8'($urandom));
      if (n > 0) frame_q[0] = cfg_addr;
      if (n > 2) frame_q[1] = cfg_cmd;
      if (pick >= 63 && pick < 70 && n > 0) frame_q[0] ^= 8'($urandom_range(1, 255));
      if (pick >= 70 && pick < 77 && n > 1) frame_q[1] ^= 8'($urandom_range(1, 255));
      if (n > 1) frame_q[n-1] = frame_crc(n - 1);
      if (pick >= 55 && pick < 63 && n > 0) frame_q[n-1] ^= 8'($urandom_range(1, 255));
      send_frame($urandom_range(0, 19) != 0, pick >= 90, $urandom_range(0, 3));
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [7:0] data);
      csr_index <= idx;
      csr_data  <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (csr_ready !== 1'b1);
   endtask

   task automatic set_config(input logic [7:0] len_data, input logic [7:0] addr,
                             input logic [7:0] cmd);
      write_reg(CSR_EXPECTED_LENGTH, len_data);
      write_reg(CSR_OWN_ADDRESS, addr);
      write_reg(CSR_EXPECTED_COMMAND, cmd);
      csr_valid <= 1'b0;
      cfg_len  = len_data[6:0];
      cfg_addr = addr;
      cfg_cmd  = cmd;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic run_phase(input int quota, input int mode);
      case (mode)
         0: begin
            idle_pct  = 0;
            stall_pct = 0;
         end
         1: begin
            idle_pct  = 72;
            stall_pct = 0;
         end
         2: begin
            idle_pct  = 0;
            stall_pct = 72;
         end
         default: begin
            idle_pct  = 30;
            stall_pct = 30;
         end
      endcase
      word_count = 0;
      while (word_count < quota) random_frame();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // empty, good frame with cr lf, colon then lf, odd digit, junk, mixed digits
      send_char(CHAR_CR);
      frame_q = '{8'h00, 8'h00, 8'hFF, 8'h00};
      frame_q[3] = frame_crc(3);
      send_frame(1'b1, 1'b0, 2);
      send_char(CHAR_COLON);
      send_char(CHAR_LF);
      send_char(CHAR_COLON);
      send_char(8'h41);
      send_char(CHAR_CR);
      foreach (odd_chars[i]) send_char(odd_chars[i]);
      send_char(CHAR_COLON);
      send_char(8'h30);
      send_char(8'h39);
      send_char(8'h66);
      send_char(8'h46);
      send_char(8'h61);
      send_char(8'h41);
      send_char(CHAR_LF);

      run_phase(150, 0);
      drain();
      set_config(8'd2, 8'hFF, 8'hFF);
      run_phase(150, 1);
      drain();
      set_config(8'd64, 8'h5A, 8'hA5);
      run_phase(300, 2);
      drain();
      set_config(8'($urandom_range(3, 12)), 8'($urandom), 8'($urandom));
      run_phase(150, 3);
      drain();
      write_reg(CSR_UNUSED, 8'($urandom));
      set_config(8'h80, 8'h00, 8'h00);
      run_phase(75, 1);
      drain();
      set_config(8'h7F, 8'($urandom), 8'($urandom));
      run_phase(75, 3);
      drain();

      if (fail_count == 0) begin
         $display("[ascii_hex_frame_receiver_crc8_core] OK");
      end else begin
         $display("[ascii_hex_frame_receiver_crc8_core] ERROR");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/core/ahfr_pkg.sv
rtl/core/ahfr_rsp_buf.sv
rtl/core/ascii_hex_frame_receiver_crc8_core.sv
bench/ahfr_checker.sv
bench/tb_ascii_hex_frame_receiver_crc8_core.sv
